>>> rtl/aob_pkg.sv
// Shared types, register indexes and constants for the alpha overlay blend unit.
package aob_pkg;

  localparam int CfgIdxW = 3;
  localparam int DimW    = 13;
  localparam int ChanW   = 3;
  localparam int PosW    = 12;
  localparam int PixW    = 8;
  localparam int NumLane = 4;
  localparam int IndexW  = 24;
  localparam int ProdW   = 2 * DimW;
  localparam int SumW    = 2 * PixW;

  localparam logic [CfgIdxW-1:0] REG_BG_WIDTH    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_BG_HEIGHT   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_OFFSET_X    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_OFFSET_Y    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_FG_CHANNELS = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_BG_CHANNELS = 3'd5;

  localparam logic [DimW-1:0]  DIM_RESET   = 13'd4096;
  localparam logic [ChanW-1:0] CHAN_RESET  = 3'd4;
  localparam logic [ChanW-1:0] ALPHA_CHANS = 3'd4;
  localparam logic [PixW-1:0]  PIX_MAX     = 8'd255;

  // stage advance enables, one per pipeline register
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } pipe_ctl_t;

  // floor(x / 255) for x below 65280
  function automatic logic [PixW-1:0] div255(input logic [SumW-1:0] x);
    logic [SumW:0] t;
    t = {1'b0, x} + {{(SumW + 1 - PixW){1'b0}}, x[SumW-1:PixW]} + 17'd1;
    return t[SumW-1:PixW];
  endfunction

endpackage

>>> rtl/alpha_overlay_blend_unit.sv
// Top level of the alpha overlay blend unit: config registers, lanes, merge stage.
//
//  channel  direction  transfer when          content
//  s_*      in         s_tvalid & s_tready    fg pixel with row/col, bg pixel at destination
//  m_*      out        m_tvalid & m_tready    dest index, inside flag, four blended channels
//  cfg_*    in         cfg_valid & cfg_ready  register index and write data
//
// One pixel per clock sustained while m_tready holds; registered stages are lane multiply,
// divide/select and merge register. Each stage holds only while the stage after it is full and
// stalled, so bubbles collapse. The row times width multiply sets stage 2.
// Reset loads config register defaults and clears stage valids; cfg_ready is always high.
module alpha_overlay_blend_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,  // fg_row, fg_col, fg_ch0..fg_ch3, bg_ch0..bg_ch3
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,  // dest_index, out_ch0..out_ch3
  output logic [0:0]  m_tuser,  // inside_res
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [aob_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [aob_pkg::DimW-1:0]    cfg_data
);
  import aob_pkg::*;

  logic [DimW-1:0]  bg_width;
  logic [DimW-1:0]  bg_height;
  logic [DimW-1:0]  offset_x;
  logic [DimW-1:0]  offset_y;
  logic [ChanW-1:0] fg_channels;
  logic [ChanW-1:0] bg_channels;

  logic      v1, v2, v3;
  pipe_ctl_t ctl;

  logic [ChanW-1:0] nch;
  logic [PixW-1:0]  alpha;
  logic [PixW-1:0]  fg_ch [NumLane];
  logic [PixW-1:0]  bg_ch [NumLane];
  logic [PixW-1:0]  lane_q [NumLane];
  logic [PixW-1:0]  out_ch [NumLane];
  logic             inside2;
  logic [IndexW-1:0] dest_index;
  logic             inside_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bg_width    <= DIM_RESET;
      bg_height   <= DIM_RESET;
      offset_x    <= '0;
      offset_y    <= '0;
      fg_channels <= CHAN_RESET;
      bg_channels <= CHAN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BG_WIDTH:    bg_width    <= cfg_data;
        REG_BG_HEIGHT:   bg_height   <= cfg_data;
        REG_OFFSET_X:    offset_x    <= cfg_data;
        REG_OFFSET_Y:    offset_y    <= cfg_data;
        REG_FG_CHANNELS: fg_channels <= cfg_data[ChanW-1:0];
        REG_BG_CHANNELS: bg_channels <= cfg_data[ChanW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ctl.en3  = !v3 || m_tready;
    ctl.en2  = !v2 || ctl.en3;
    ctl.en1  = !v1 || ctl.en2;
    s_tready = ctl.en1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ctl.en1) v1 <= s_tvalid;
      if (ctl.en2) v2 <= v1;
      if (ctl.en3) v3 <= v2;
    end
  end

  always_comb begin
    nch = (fg_channels < bg_channels) ? fg_channels : bg_channels;
    if (nch > ALPHA_CHANS) nch = ALPHA_CHANS;
    for (int k = 0; k < NumLane; k++) begin
      fg_ch[k] = s_tdata[2*PosW + k*PixW +: PixW];
      bg_ch[k] = s_tdata[2*PosW + (NumLane + k)*PixW +: PixW];
    end
    alpha = (fg_channels >= ALPHA_CHANS) ? fg_ch[NumLane-1] : PIX_MAX;
  end

  for (genvar k = 0; k < NumLane; k++) begin : g_lane
    aob_lane u_lane (
      .clk   (clk),
      .ctl   (ctl),
      .s     (fg_ch[k]),
      .d     (bg_ch[k]),
      .a     (alpha),
      .blend (nch > ChanW'(k)),
      .q     (lane_q[k])
    );
  end

  aob_addr u_addr (
    .clk        (clk),
    .ctl        (ctl),
    .fg_row     (s_tdata[PosW-1:0]),
    .fg_col     (s_tdata[2*PosW-1:PosW]),
    .bg_width   (bg_width),
    .bg_height  (bg_height),
    .offset_x   (offset_x),
    .offset_y   (offset_y),
    .inside2    (inside2),
    .dest_index (dest_index),
    .inside_res (inside_res)
  );

  // merge: outside the background every field reads zero
  always_ff @(posedge clk) begin
    if (ctl.en3) begin
      for (int k = 0; k < NumLane; k++) begin
        out_ch[k] <= inside2 ? lane_q[k] : '0;
      end
    end
  end

  assign m_tvalid = v3;
  assign m_tuser  = inside_res;
  assign m_tdata  = {out_ch[3], out_ch[2], out_ch[1], out_ch[0], dest_index};

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready) else $error("input stalled with empty output stage");

  a_stage_move: assert property (@(posedge clk) disable iff (rst)
    (v1 && ctl.en2) |=> v2) else $error("stage 1 item lost");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0)) else $error("outside result not zero");

  a_hold_full: assert property (@(posedge clk) disable iff (rst)
    (v2 && v3 && !m_tready) |=> (v2 && v3)) else $error("stalled stage dropped item");

endmodule

>>> rtl/aob_lane.sv
// One channel blend lane: weighted sum, then divide by 255 or pass through.
module aob_lane (
  input  logic                    clk,
  input  aob_pkg::pipe_ctl_t      ctl,
  input  logic [aob_pkg::PixW-1:0] s,
  input  logic [aob_pkg::PixW-1:0] d,
  input  logic [aob_pkg::PixW-1:0] a,
  input  logic                    blend,
  output logic [aob_pkg::PixW-1:0] q
);
  import aob_pkg::*;

  logic [SumW-1:0] sum1;
  logic [PixW-1:0] d1;
  logic            blend1;

  always_ff @(posedge clk) begin
    if (ctl.en1) begin
      sum1   <= SumW'(s) * SumW'(a) + SumW'(d) * SumW'(PIX_MAX - a);
      d1     <= d;
      blend1 <= blend;
    end
    if (ctl.en2) begin
      q <= blend1 ? div255(sum1) : d1;
    end
  end

endmodule

>>> rtl/aob_addr.sv
// Destination placement: clip test, row times width, column add.
module aob_addr (
  input  logic                      clk,
  input  aob_pkg::pipe_ctl_t        ctl,
  input  logic [aob_pkg::PosW-1:0]   fg_row,
  input  logic [aob_pkg::PosW-1:0]   fg_col,
  input  logic [aob_pkg::DimW-1:0]   bg_width,
  input  logic [aob_pkg::DimW-1:0]   bg_height,
  input  logic [aob_pkg::DimW-1:0]   offset_x,
  input  logic [aob_pkg::DimW-1:0]   offset_y,
  output logic                      inside2,
  output logic [aob_pkg::IndexW-1:0] dest_index,
  output logic                      inside_res
);
  import aob_pkg::*;

  logic [DimW:0]    row_sum;
  logic [DimW:0]    col_sum;
  logic             in_now;
  logic [DimW-1:0]  row1;
  logic [DimW-1:0]  col1;
  logic             inside1;
  logic [ProdW-1:0] prod2;
  logic [DimW-1:0]  col2;
  logic [ProdW-1:0] idx_sum;

  always_comb begin
    row_sum = {2'b00, fg_row} + {offset_y[DimW-1], offset_y};
    col_sum = {2'b00, fg_col} + {offset_x[DimW-1], offset_x};
    in_now  = !row_sum[DimW] && !col_sum[DimW] &&
              (row_sum[DimW-1:0] < bg_height) && (col_sum[DimW-1:0] < bg_width);
    idx_sum = prod2 + {{(ProdW - DimW){1'b0}}, col2};
  end

  always_ff @(posedge clk) begin
    if (ctl.en1) begin
      row1    <= row_sum[DimW-1:0];
      col1    <= col_sum[DimW-1:0];
      inside1 <= in_now;
    end
    if (ctl.en2) begin
      prod2   <= ProdW'(row1) * ProdW'(bg_width);
      col2    <= col1;
      inside2 <= inside1;
    end
    if (ctl.en3) begin
      dest_index <= inside2 ? idx_sum[IndexW-1:0] : '0;
      inside_res <= inside2;
    end
  end

endmodule

>>> bench/tb_alpha_overlay_blend_unit.sv
// Self-checking testbench for alpha_overlay_blend_unit: placement, clipping and blend results.
module tb_alpha_overlay_blend_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY        = 3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RAND_PHASES    = 11;
  localparam int PHASE_ITEMS    = 150;
  localparam int REPORT_CAP     = 40;

  // indexes past the register file, writes there must be ignored
  localparam logic [aob_pkg::CfgIdxW-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [aob_pkg::CfgIdxW-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [3:0][7:0] bg_ch;
    logic [3:0][7:0] fg_ch;
    logic [11:0]     fg_col;
    logic [11:0]     fg_row;
  } pixel_t;

  typedef struct packed {
    logic            inside_res;
    logic [3:0][7:0] out_ch;
    logic [23:0]     dest_index;
  } blend_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [87:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [aob_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [aob_pkg::DimW-1:0]    cfg_data  = '0;

  alpha_overlay_blend_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow copy of the register file
  logic [12:0]        cur_bg_w  = aob_pkg::DIM_RESET;
  logic [12:0]        cur_bg_h  = aob_pkg::DIM_RESET;
  logic signed [12:0] cur_ofs_x = '0;
  logic signed [12:0] cur_ofs_y = '0;
  logic [2:0]         cur_fg_n  = aob_pkg::CHAN_RESET;
  logic [2:0]         cur_bg_n  = aob_pkg::CHAN_RESET;

  pixel_t pixel_feed[$];
  blend_t pending_blends[$];
  pixel_t cur_px;
  int     burst_left = 0;
  int     gap_left = 0;
  int     rdy_mode = 0;
  int     rdy_left = 0;
  int     mismatch_cnt = 0;
  int     idle_cycles = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic blend_t composite_pixel(pixel_t px);
    blend_t r;
    int row, col, nch, alpha, pos;
    r = '0;
    row = int'(px.fg_row) + int'(cur_ofs_y);
    col = int'(px.fg_col) + int'(cur_ofs_x);
    if (row < 0 || col < 0 || row >= int'(cur_bg_h) || col >= int'(cur_bg_w)) return r;
    pos = row * int'(cur_bg_w) + col;
    r.dest_index = pos[23:0];
    r.inside_res = 1'b1;
    nch = (cur_fg_n < cur_bg_n) ? int'(cur_fg_n) : int'(cur_bg_n);
    if (nch > aob_pkg::NumLane) nch = aob_pkg::NumLane;
    alpha = (cur_fg_n >= aob_pkg::ALPHA_CHANS) ? int'(px.fg_ch[3]) : int'(aob_pkg::PIX_MAX);
    for (int k = 0; k < aob_pkg::NumLane; k++) begin
      if (k < nch) begin
        r.out_ch[k] = 8'((int'(px.fg_ch[k]) * alpha + int'(px.bg_ch[k]) * (255 - alpha)) / 255);
      end else begin
        r.out_ch[k] = px.bg_ch[k];
      end
    end
    return r;
  endfunction

  // source coordinate that lands near the background, or anywhere
  function automatic logic [11:0] pick_coord(int span, int ofs);
    int dst, p;
    if ($urandom_range(0, 3) == 0) return 12'($urandom);
    dst = int'($urandom_range(0, span + 1)) - 1;
    p = dst - ofs;
    if (p < 0 || p > 4095) return 12'($urandom);
    return 12'(p);
  endfunction

  function automatic logic [12:0] pick_dim();
    case ($urandom_range(0, 9))
      0: return 13'd0;
      1: return 13'd1;
      2: return 13'd8191;
      3: return 13'd4096;
      4, 5: return 13'($urandom_range(1, 64));
      default: return 13'($urandom_range(1, 4096));
    endcase
  endfunction

  function automatic logic signed [12:0] pick_offset();
    case ($urandom_range(0, 7))
      0: return -13'sd4096;
      1: return 13'sd4095;
      2: return 13'sd0;
      default: return 13'($urandom);
    endcase
  endfunction

  function automatic logic [2:0] pick_chans();
    if ($urandom_range(0, 9) < 7) return 3'($urandom_range(1, 4));
    return 3'($urandom_range(0, 7));
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [12:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      aob_pkg::REG_BG_WIDTH:    cur_bg_w  = val;
      aob_pkg::REG_BG_HEIGHT:   cur_bg_h  = val;
      aob_pkg::REG_OFFSET_X:    cur_ofs_x = val;
      aob_pkg::REG_OFFSET_Y:    cur_ofs_y = val;
      aob_pkg::REG_FG_CHANNELS: cur_fg_n  = val[2:0];
      aob_pkg::REG_BG_CHANNELS: cur_bg_n  = val[2:0];
      default: ;
    endcase
  endtask

  // channel counts go out with junk in the unused upper data bits
  task automatic program_setting(input logic [12:0] w, input logic [12:0] h,
                                 input logic signed [12:0] ox, input logic signed [12:0] oy,
                                 input logic [2:0] fn, input logic [2:0] bn);
    logic [12:0] word;
    write_reg(aob_pkg::REG_BG_WIDTH, w);
    write_reg(aob_pkg::REG_BG_HEIGHT, h);
    write_reg(aob_pkg::REG_OFFSET_X, ox);
    write_reg(aob_pkg::REG_OFFSET_Y, oy);
    word = 13'($urandom);
    word[2:0] = fn;
    write_reg(aob_pkg::REG_FG_CHANNELS, word);
    word = 13'($urandom);
    word[2:0] = bn;
    write_reg(aob_pkg::REG_BG_CHANNELS, word);
    if ($urandom_range(0, 1) == 1)
      write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, 13'($urandom));
  endtask

  task automatic queue_pixel(input int row, input int col,
                             input logic [31:0] fg, input logic [31:0] bg);
    pixel_t px;
    px.fg_row = 12'(row);
    px.fg_col = 12'(col);
    px.fg_ch  = fg;
    px.bg_ch  = bg;
    pixel_feed.push_back(px);
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (pixel_feed.size() != 0 || s_tvalid || pending_blends.size() != 0);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  task automatic report(input string field, input longint want, input longint got);
    mismatch_cnt++;
    if (mismatch_cnt <= REPORT_CAP)
      $error("%s: expected %0d, got %0d", field, want, got);
  endtask

  // sender: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) pending_blends.push_back(composite_pixel(cur_px));
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pixel_feed.size() != 0) begin
          cur_px = pixel_feed.pop_front();
          s_tdata  <= cur_px;
          s_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 48);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern switches between four modes after runs of random length
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (rdy_left == 0) begin
        rdy_mode = $urandom_range(0, 3);
        rdy_left = $urandom_range(8, 80);
      end else begin
        rdy_left--;
      end
      case (rdy_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= rdy_left[2];
      endcase
    end
  end

  always @(posedge clk) begin : result_check
    blend_t want, got;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser[0], m_tdata};
      if (pending_blends.size() == 0) begin
        report("dest_index (no result pending)", -1, got.dest_index);
      end else begin
        want = pending_blends.pop_front();
        if (got.dest_index !== want.dest_index) report("dest_index", want.dest_index, got.dest_index);
        if (got.inside_res !== want.inside_res)
          report("inside_res", want.inside_res, got.inside_res);
        for (int k = 0; k < aob_pkg::NumLane; k++) begin
          if (got.out_ch[k] !== want.out_ch[k])
            report($sformatf("out_ch%0d", k), want.out_ch[k], got.out_ch[k]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    pixel_t px;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset values: full size, no offset, four channels with alpha
    queue_pixel(0, 0, 32'h00FFFFFF, 32'h00000000);
    queue_pixel(4095, 4095, 32'hFF123456, 32'hABCDEF01);
    queue_pixel(100, 200, 32'h80FF00FF, 32'h00FF00FF);
    queue_pixel(1, 1, 32'hFFFFFFFF, 32'hFFFFFFFF);
    queue_pixel(2, 3, 32'h01FE7F80, 32'h55AA33CC);
    wait_idle();

    // largest dimensions and offsets, index wraps past 24 bits
    program_setting(13'd8191, 13'd8191, 13'sd4095, 13'sd4095, 3'd4, 3'd4);
    queue_pixel(4095, 4095, 32'hC0102030, 32'h40F0E0D0);
    queue_pixel(0, 0, 32'h7F8899AA, 32'h11223344);
    wait_idle();

    // most negative placement
    program_setting(13'd8191, 13'd8191, -13'sd4096, -13'sd4096, 3'd4, 3'd4);
    queue_pixel(4095, 4095, 32'hFFFFFFFF, 32'hFFFFFFFF);
    queue_pixel(0, 0, 32'hFFFFFFFF, 32'hFFFFFFFF);
    wait_idle();

    // empty background
    program_setting(13'd0, 13'd0, 13'sd0, 13'sd0, 3'd4, 3'd4);
    queue_pixel(0, 0, 32'hFF000000, 32'h12345678);
    wait_idle();

    // right and bottom edges, three foreground channels copy without alpha
    program_setting(13'd10, 13'd6, 13'sd0, 13'sd0, 3'd3, 3'd4);
    queue_pixel(5, 9, 32'h00A1B2C3, 32'h9F8E7D6C);
    queue_pixel(6, 9, 32'h00A1B2C3, 32'h9F8E7D6C);
    queue_pixel(5, 10, 32'h00A1B2C3, 32'h9F8E7D6C);
    wait_idle();

    // zero channels: everything passes the background
    program_setting(13'd4096, 13'd4096, 13'sd0, 13'sd0, 3'd0, 3'd4);
    queue_pixel(7, 7, 32'hFFFFFFFF, 32'h01020304);
    wait_idle();

    // counts above four act as four with alpha
    program_setting(13'd4096, 13'd4096, 13'sd0, 13'sd0, 3'd7, 3'd5);
    queue_pixel(8, 9, 32'h40FF8000, 32'h00FF0080);
    queue_pixel(9, 8, 32'hBF10F0A5, 32'hEE5A0F77);
    wait_idle();

    program_setting(13'd4096, 13'd4096, 13'sd0, 13'sd0, 3'd4, 3'd1);
    queue_pixel(3, 4, 32'h60C0C0C0, 32'h20202020);
    wait_idle();

    program_setting(13'd4096, 13'd4096, 13'sd0, 13'sd0, 3'd2, 3'd0);
    queue_pixel(4, 3, 32'h60C0C0C0, 32'h20202020);
    wait_idle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      program_setting(pick_dim(), pick_dim(), pick_offset(), pick_offset(),
                      pick_chans(), pick_chans());
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        px.fg_ch  = $urandom;
        px.bg_ch  = $urandom;
        case ($urandom_range(0, 9))
          0: px.fg_ch[3] = 8'h00;
          1: px.fg_ch[3] = 8'hFF;
          default: ;
        endcase
        px.fg_row = pick_coord(int'(cur_bg_h), int'(cur_ofs_y));
        px.fg_col = pick_coord(int'(cur_bg_w), int'(cur_ofs_x));
        pixel_feed.push_back(px);
      end
      wait_idle();
    end

    repeat (LATENCY + 5) @(posedge clk);
    if (mismatch_cnt == 0 && pending_blends.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> alpha_overlay_blend_unit.f
rtl/aob_pkg.sv
rtl/aob_lane.sv
rtl/aob_addr.sv
rtl/alpha_overlay_blend_unit.sv
bench/tb_alpha_overlay_blend_unit.sv
